// ===== rtl/bds_pkg.sv =====
package bds_pkg;

  localparam int MAX_OVERSAMPLE = 32;
  localparam int MIN_OVERSAMPLE = 4;
  localparam int DIVISOR_BITS   = 13;

  localparam int CLK_W  = 32;
  localparam int BAUD_W = 24;
  localparam int OSR_W  = 6;
  localparam int ERR_W  = 32;
  // full-width divisor candidate (clock / (baud * 4) + 1 fits)
  localparam int DV_W   = 32;
  // divider denominator: (d + 1) * osr can exceed 32 bits
  localparam int DEN_W  = 33;
  localparam int STEP_W = $clog2(CLK_W);

  localparam logic [DIVISOR_BITS-1:0] DIV_LIMIT = '1;
  localparam logic [OSR_W-1:0] OSR_MIN = OSR_W'(MIN_OVERSAMPLE);
  localparam logic [OSR_W-1:0] OSR_MAX = OSR_W'(MAX_OVERSAMPLE);

  typedef struct packed {
    logic [CLK_W-1:0]  clock_hz;
    logic [BAUD_W-1:0] baud_rate;
  } bds_req_t;

  typedef struct packed {
    logic [DIVISOR_BITS-1:0] divisor;
    logic [OSR_W-1:0]        oversample;
    logic [ERR_W-1:0]        rate_error;
    logic                    divisor_saturated;
  } bds_rsp_t;

  typedef struct packed {
    logic             start;
    logic [CLK_W-1:0] dividend;
    logic [DEN_W-1:0] denom;
  } bds_div_ctl_t;

  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quotient;
  } bds_div_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUOT_GO,
    S_QUOT,
    S_LO_GO,
    S_LO,
    S_HI_GO,
    S_HI,
    S_DONE
  } bds_state_t;

endpackage

// ===== rtl/bds_div.sv =====
module bds_div (
  input  logic                  clk,
  input  logic                  rst,
  input  bds_pkg::bds_div_ctl_t ctl,
  output bds_pkg::bds_div_sts_t sts
);
  import bds_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [CLK_W-1:0]  quo;
  logic [DEN_W:0]    shifted;
  logic              ge;

  assign shifted = {rem, quo[CLK_W-1]};
  assign ge      = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(CLK_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      den <= ctl.denom;
      quo <= ctl.dividend;
    end else if (busy) begin
      rem <= ge ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
      quo <= {quo[CLK_W-2:0], ge};
    end
  end

  assign sts.done     = done;
  assign sts.quotient = quo;

endmodule

// ===== rtl/baud_divisor_search.sv =====
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   clock_hz, baud_rate
// rsp      out        rsp_valid/rsp_ready   divisor, oversample, rate_error, divisor_saturated
//
// One request at a time. Each ratio costs up to three passes of the shared
// bit-serial divider, each launched from its own issue state; all 29
// ratios are tried in turn, fewer on an exact match.
// req_ready is high only when idle; the result holds until rsp_ready.
// Synchronous reset returns to idle; no clearing pass.
module baud_divisor_search (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bds_pkg::bds_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bds_pkg::bds_rsp_t rsp
);
  import bds_pkg::*;

  bds_state_t       state, state_next;
  bds_div_ctl_t     div_ctl;
  bds_div_sts_t     div_sts;

  logic [CLK_W-1:0]  clk_hz;
  logic [BAUD_W-1:0] baud;
  logic [OSR_W-1:0]  osr;
  logic [DV_W-1:0]   dv;
  logic [DV_W-1:0]   best_div;
  logic [OSR_W-1:0]  best_osr;
  logic [ERR_W-1:0]  best_err;

  logic [DV_W-1:0]   mul_a;
  logic [ERR_W-1:0]  err;
  logic              take;
  logic              exact;
  logic              sat;

  bds_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_ctl),
    .sts (div_sts)
  );

  assign mul_a = (state == S_HI_GO) ? DV_W'(dv + 1'b1) : dv;
  assign err   = (div_sts.quotient >= CLK_W'(baud)) ?
                 ERR_W'(div_sts.quotient - CLK_W'(baud)) :
                 ERR_W'(CLK_W'(baud) - div_sts.quotient);
  assign take  = best_err >= err;
  assign exact = err == '0;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (req_valid) state_next = S_QUOT_GO;
      S_QUOT_GO: state_next = S_QUOT;
      S_QUOT:    if (div_sts.done) state_next = S_LO_GO;
      S_LO_GO:   state_next = S_LO;
      S_LO:      if (div_sts.done) state_next = (take && exact) ? S_DONE : S_HI_GO;
      S_HI_GO:   state_next = S_HI;
      S_HI: begin
        if (div_sts.done) begin
          state_next = ((take && exact) || osr == OSR_MAX) ? S_DONE : S_QUOT_GO;
        end
      end
      S_DONE:    if (rsp_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready        = 1'b0;
    rsp_valid        = 1'b0;
    div_ctl.start    = 1'b0;
    div_ctl.dividend = clk_hz;
    div_ctl.denom    = DEN_W'(baud) * DEN_W'(osr);
    unique case (state)
      S_IDLE:    req_ready = 1'b1;
      S_QUOT_GO: div_ctl.start = 1'b1;
      S_LO_GO, S_HI_GO: begin
        div_ctl.start = 1'b1;
        div_ctl.denom = DEN_W'(mul_a) * DEN_W'(osr);
      end
      S_DONE:    rsp_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          clk_hz   <= req.clock_hz;
          baud     <= (req.baud_rate == '0) ? BAUD_W'(1) : req.baud_rate;
          osr      <= OSR_MIN;
          best_err <= '1;
          best_div <= '0;
          best_osr <= OSR_MIN;
        end
      end
      S_QUOT: begin
        if (div_sts.done) begin
          dv <= (div_sts.quotient == '0) ? DV_W'(1) : div_sts.quotient;
        end
      end
      S_LO: begin
        if (div_sts.done && take) begin
          best_err <= err;
          best_div <= dv;
          best_osr <= osr;
        end
      end
      S_HI: begin
        if (div_sts.done) begin
          if (take) begin
            best_err <= err;
            best_div <= DV_W'(dv + 1'b1);
            best_osr <= osr;
          end
          osr <= osr + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign sat                   = best_div > DV_W'(DIV_LIMIT);
  assign rsp.divisor           = sat ? DIV_LIMIT : best_div[DIVISOR_BITS-1:0];
  assign rsp.oversample        = best_osr;
  assign rsp.rate_error        = best_err;
  assign rsp.divisor_saturated = sat;

endmodule

// ===== rtl/bds_checker.sv =====
module bds_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input bds_pkg::bds_req_t req,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input bds_pkg::bds_rsp_t rsp
);
  import bds_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken while a response is pending");

  a_no_early_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid)
    else $error("response in the cycle after a request");

  a_osr_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.oversample >= OSR_MIN && rsp.oversample <= OSR_MAX
                  && rsp.divisor != '0)
    else $error("ratio out of range or zero divisor");

  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.divisor_saturated |-> rsp.divisor == DIV_LIMIT)
    else $error("saturated divisor not clamped");

endmodule

bind baud_divisor_search bds_checker u_bds_checker (.*);
